[rtl/kls_pkg.sv]
// kls_pkg: shared types and constants for the kth-largest stream tracker.
// No dependencies; used by kls_slot, the top level and the checker.
`timescale 1ns / 1ps

package kls_pkg;

  localparam int VALUE_W = 32;  // stream value width
  localparam int RANK_W  = 5;   // rank register width

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [RANK_W-1:0]         rank_t;

  // Per-slot update control from the top level.
  typedef struct packed {
    logic upd;       // slot loads a new value this cycle
    logic take_new;  // load the incoming sample instead of the upper neighbor
  } slot_ctrl_t;

endpackage

[rtl/kls_slot.sv]
// kls_slot: one entry of the sorted held-value array with its compare.
// Depends on kls_pkg.
`timescale 1ns / 1ps

module kls_slot (
  input  logic                clk,
  input  kls_pkg::value_t     sample,
  input  logic                slot_live,   // entry is inside the held count
  input  kls_pkg::value_t     upper_value, // neighbor one rank above
  input  kls_pkg::slot_ctrl_t ctrl,
  output logic                ge,          // live and >= sample
  output kls_pkg::value_t     value,
  output kls_pkg::value_t     value_next
);

  assign ge = slot_live && (value >= sample);

  always_comb begin
    value_next = value;
    if (ctrl.upd) begin
      value_next = ctrl.take_new ? sample : upper_value;
    end
  end

  // Payload only; entries past the held count are never read.
  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

[rtl/kth_largest_stream_tracker.sv]
// kth_largest_stream_tracker: top level, keeps the k largest stream values.
// Depends on kls_pkg and kls_slot.
//
//   channel   direction  handshake            payload
//   -------   ---------  -------------------  ------------------------------
//   in        sink       in_valid / in_stall  sample_value (s32)
//   out       source     out_valid/out_stall  kth_value (s32), rank_filled
//   cfg       sink       cfg_wr_en            cfg_wr_data (rank_k, 5 bits)
//
// One request per clock sustained while out_stall does not hold the result.
// A request is taken into the input register, where the slot compare/insert
// runs, and then loads the result register, which raises out_valid.
// The per-cycle figure is set by the single-pass compare across all slots.
// Reset (rst, synchronous) empties both stages, zeroes the held count and
// sets rank_k to 1; slot contents are left as they are.
// A stalled result holds; the input register still takes one more request.
`timescale 1ns / 1ps

module kth_largest_stream_tracker #(
  parameter int MAX_RANK = 16
) (
  input  logic                clk,
  input  logic                rst,
  // input requests
  input  logic                in_valid,
  output logic                in_stall,
  input  kls_pkg::value_t     sample_value,
  // results
  output logic                out_valid,
  input  logic                out_stall,
  output kls_pkg::value_t     kth_value,
  output logic                rank_filled,
  // rank register
  input  logic                cfg_wr_en,
  input  kls_pkg::rank_t      cfg_wr_data
);

  // count holds 0..MAX_RANK; index addresses one slot
  localparam int KW = $clog2(MAX_RANK + 1);
  localparam int IW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;

  // Effective k: zero reads as one, anything above capacity as capacity.
  function automatic logic [KW-1:0] eff_k(input kls_pkg::rank_t r);
    logic [KW-1:0] res;
    if (r == '0) begin
      res = KW'(1);
    end else if (int'(r) > MAX_RANK) begin
      res = KW'(MAX_RANK);
    end else begin
      res = KW'(r);
    end
    return res;
  endfunction

  // ---------------- registers ----------------
  kls_pkg::rank_t   rank_k;
  logic [KW-1:0]    count;       // live entries, always <= k
  logic             s1_valid;    // input register
  kls_pkg::value_t  s1_value;

  // ---------------- slot array ----------------
  logic              ge       [MAX_RANK];
  kls_pkg::value_t   slot_val [MAX_RANK];
  kls_pkg::value_t   slot_nxt [MAX_RANK];
  logic [MAX_RANK-1:0] ge_vec;

  logic              fire;       // stage 1 request processed this cycle
  logic              ins_en;     // sample earns a place among the top k
  logic [KW-1:0]     k_cur;
  logic [KW-1:0]     k_m1;
  logic [KW-1:0]     last;       // deepest slot touched by the shift
  logic [KW-1:0]     count_next;
  logic [KW-1:0]     sel;
  logic [KW-1:0]     k_cfg;

  assign k_cur = eff_k(rank_k);
  assign k_m1  = k_cur - KW'(1);
  assign k_cfg = eff_k(cfg_wr_data);

  // Result register accepts when empty or being drained.
  assign fire     = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !fire;

  // Entries are sorted high to low, so the >= flags form a prefix.
  // Insertion point < k  <=>  slot k-1 is not >= sample.
  assign ins_en = !ge_vec[k_m1[IW-1:0]];
  assign last   = (count < k_cur) ? count : k_m1;

  always_comb begin
    count_next = count;
    if (ins_en && (count < k_cur)) begin
      count_next = count + KW'(1);
    end
  end

  for (genvar i = 0; i < MAX_RANK; i++) begin : g_slot
    kls_pkg::slot_ctrl_t ctrl;
    kls_pkg::value_t     upper;
    logic                at_or_after;  // slot index >= insertion point

    assign at_or_after = !ge[i];

    if (i == 0) begin : g_top
      assign ctrl.take_new = 1'b1;
      assign upper = s1_value;
    end else begin : g_rest
      assign ctrl.take_new = ge[i-1];
      assign upper = slot_val[i-1];
    end

    assign ctrl.upd = fire && ins_en && at_or_after && (KW'(i) <= last);
    assign ge_vec[i] = ge[i];

    kls_slot u_slot (
      .clk         (clk),
      .sample      (s1_value),
      .slot_live   (KW'(i) < count),
      .upper_value (upper),
      .ctrl        (ctrl),
      .ge          (ge[i]),
      .value       (slot_val[i]),
      .value_next  (slot_nxt[i])
    );
  end

  // Smallest held value after the update sits at count_next-1 (count_next >= 1).
  assign sel = count_next - KW'(1);

  // ---------------- control and result registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rank_k    <= kls_pkg::rank_t'(1);
      count     <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        // lowering k drops smallest entries; user keeps block idle, not enforced
        rank_k <= cfg_wr_data;
        if (count > k_cfg) begin
          count <= k_cfg;
        end
      end else if (fire) begin
        count <= count_next;
      end

      if (!in_stall) begin
        s1_valid <= in_valid;
      end

      if (fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_value <= sample_value;
    end
    if (fire) begin
      kth_value   <= slot_nxt[sel[IW-1:0]];
      rank_filled <= (count_next == k_cur);
    end
  end

endmodule

[rtl/kls_checker.sv]
// kls_checker: port-level assertions for kth_largest_stream_tracker.
// Depends on kls_pkg; attached to the top level by the bind below.
`timescale 1ns / 1ps

module kls_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input kls_pkg::value_t kth_value,
  input logic            rank_filled,
  input logic            cfg_wr_en
);

  // Tracks whether a full-rank result was seen since the last rank write.
  logic            filled_seen;
  kls_pkg::value_t last_kth;

  always_ff @(posedge clk) begin
    if (rst || cfg_wr_en) begin
      filled_seen <= 1'b0;
    end else if (out_valid && !out_stall && rank_filled) begin
      filled_seen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_stall) begin
      last_kth <= kth_value;
    end
  end

  // Once k values are held, later results stay full until k is rewritten.
  a_filled_sticky: assert property (@(posedge clk) disable iff (rst)
    (out_valid && filled_seen) |-> rank_filled)
    else $error("rank_filled dropped without a rank write");

  // The kth largest can only rise while k is unchanged.
  a_kth_monotonic: assert property (@(posedge clk) disable iff (rst)
    (out_valid && filled_seen) |-> (kth_value >= last_kth))
    else $error("kth_value decreased with a full rank");

  // With no result waiting, the input side is never stalled.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while result register empty");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(kth_value) && $stable(rank_filled)))
    else $error("stalled result changed");

endmodule

bind kth_largest_stream_tracker kls_checker u_kls_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .kth_value   (kth_value),
  .rank_filled (rank_filled),
  .cfg_wr_en   (cfg_wr_en)
);

[test/tb.sv]
`timescale 1ns / 1ps
// tb: self-checking bench for kth_largest_stream_tracker (top-k tracker, rank register).
// Depends on kls_pkg and the RTL. Holds its own sorted top-k list to predict each result.

module tb;

  localparam int              MAX_RANK    = 16;
  localparam int              RAND_ITEMS  = 1250;
  localparam int              CYCLE_LIMIT = 400000;
  localparam kls_pkg::value_t VMIN        = 32'sh8000_0000;
  localparam kls_pkg::value_t VMAX        = 32'sh7fff_ffff;

  // Directed plan rows: either a sample request or a rank register write.
  typedef enum logic {ROW_SAMPLE, ROW_RANK} row_kind_t;

  typedef struct packed {
    kls_pkg::value_t kth;
    logic            filled;
  } kth_result_t;

  typedef struct packed {
    row_kind_t       kind;
    kls_pkg::rank_t  rank;    // ROW_RANK only
    kls_pkg::value_t val;     // ROW_SAMPLE only
    logic            typed;   // result below is written out by hand
    kls_pkg::value_t kth;
    logic            filled;
  } stim_row_t;

  // DUT ports
  logic            clk = 1'b0;
  logic            rst;
  logic            in_valid;
  logic            in_stall;
  kls_pkg::value_t sample_value;
  logic            out_valid;
  logic            out_stall = 1'b0;
  kls_pkg::value_t kth_value;
  logic            rank_filled;
  logic            cfg_wr_en;
  kls_pkg::rank_t  cfg_wr_data;

  // Predictor state: values kept largest first, count of valid entries, rank register.
  kls_pkg::value_t top_vals [MAX_RANK];
  int unsigned     top_count;
  kls_pkg::rank_t  rank_reg;

  kth_result_t kth_expected [$];
  int          errors = 0;
  int          burst_left;
  int          cycle_count = 0;

  // Receiver stall pattern state
  logic [1:0]  stall_mode = 2'd0;
  logic [15:0] stall_pattern = 16'h0;
  logic [3:0]  stall_phase = 4'd0;
  int          stall_left = 0;

  always #4 clk = ~clk;

  kth_largest_stream_tracker #(
    .MAX_RANK(MAX_RANK)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample_value(sample_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kth_value   (kth_value),
    .rank_filled (rank_filled),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Rank 0 acts as 1, anything above capacity is clamped to MAX_RANK.
  function automatic int unsigned rank_limit(input kls_pkg::rank_t r);
    if (r == '0) return 1;
    if (r > MAX_RANK) return MAX_RANK;
    return int'(r);
  endfunction

  // Insert one sample into the predicted top-k list and return the new result.
  function automatic kth_result_t track_sample(input kls_pkg::value_t v);
    int unsigned k;
    int unsigned n;
    int unsigned pos;
    int unsigned last;
    int unsigned i;
    kth_result_t res;
    k = rank_limit(rank_reg);
    n = (top_count > k) ? k : top_count;
    pos = 0;
    // insertion point = number of held values >= v, so ties never displace
    while (pos < n && top_vals[pos] >= v) pos++;
    if (pos < k) begin
      last = (n < k) ? n : k - 1;
      for (i = last; i > pos; i--) top_vals[i] = top_vals[i-1];
      top_vals[pos] = v;
      if (n < k) n++;
    end
    top_count = n;
    res.kth = top_vals[n-1];
    res.filled = (n == k);
    return res;
  endfunction

  // Present one request, hold it until accepted, then record its result.
  // The burst bookkeeping decides whether valid drops after this request.
  task automatic send_sample(input kls_pkg::value_t v, input logic typed,
                             input kth_result_t hand_res);
    kth_result_t res;
    in_valid <= 1'b1;
    sample_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = track_sample(v);
    kth_expected.push_back(typed ? hand_res : res);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      // mostly short bursts, now and then a long stretch with no gaps
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(0, 4);
    end
  endtask

  // Rank writes happen only with the block idle: valid low and every result back.
  // This is also the pause where the sender waits out the whole pipeline.
  task automatic set_rank(input kls_pkg::rank_t r);
    if (in_valid) in_valid <= 1'b0;
    while (kth_expected.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= r;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    rank_reg = r;
    // lowering k keeps only the largest values; they don't come back later
    if (top_count > rank_limit(r)) top_count = rank_limit(r);
  endtask

  // Receiver: stall behavior switches at random between
  // no stall, a fixed random pattern, heavy random stalls and long runs.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= 2'($urandom_range(0, 3));
      stall_pattern <= 16'($urandom);
      stall_left <= $urandom_range(16, 96);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= stall_pattern[stall_phase];
      2'd2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_phase < 4'd10);
    endcase
    stall_phase <= stall_phase + 4'd1;
  end

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    kth_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (kth_expected.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending: expected none, %s %0d %s %0b",
                 $time, "got kth_value", kth_value, "rank_filled", rank_filled);
      end else begin
        want = kth_expected.pop_front();
        if (kth_value !== want.kth) begin
          errors++;
          $display("%0t: kth_value mismatch: expected %0d, got %0d", $time, want.kth, kth_value);
        end
        if (rank_filled !== want.filled) begin
          errors++;
          $display("%0t: rank_filled mismatch: expected %0b, got %0b",
                   $time, want.filled, rank_filled);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t plan [$];
    kth_result_t hand_res;
    kls_pkg::rank_t new_rank;
    kls_pkg::value_t v;
    int items;
    int phase_len;

    rst <= 1'b1;
    in_valid <= 1'b0;
    sample_value <= '0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    top_count = 0;
    rank_reg = kls_pkg::rank_t'(1);
    burst_left = 0;

    // Directed plan. After reset k is 1.
    plan.push_back('{ROW_SAMPLE, '0, VMIN, 1'b1, VMIN, 1'b1});  // first value, k = 1
    plan.push_back('{ROW_SAMPLE, '0, VMAX, 1'b1, VMAX, 1'b1});
    plan.push_back('{ROW_SAMPLE, '0, VMIN, 1'b1, VMAX, 1'b1});  // smaller, dropped
    plan.push_back('{ROW_SAMPLE, '0, VMAX, 1'b1, VMAX, 1'b1});  // tie, not inserted
    plan.push_back('{ROW_RANK, kls_pkg::rank_t'(0), '0, 1'b0, '0, 1'b0});  // zero acts as one
    plan.push_back('{ROW_SAMPLE, '0, 32'sd5, 1'b1, VMAX, 1'b1});
    plan.push_back('{ROW_RANK, kls_pkg::rank_t'(3), '0, 1'b0, '0, 1'b0});  // raised mid-stream
    plan.push_back('{ROW_SAMPLE, '0, -32'sd1, 1'b1, -32'sd1, 1'b0});
    plan.push_back('{ROW_SAMPLE, '0, -32'sd1, 1'b1, -32'sd1, 1'b1});
    plan.push_back('{ROW_SAMPLE, '0, -32'sd1, 1'b1, -32'sd1, 1'b1});  // equal to smallest
    plan.push_back('{ROW_SAMPLE, '0, 32'sd0, 1'b1, -32'sd1, 1'b1});
    plan.push_back('{ROW_SAMPLE, '0, 32'sd7, 1'b1, 32'sd0, 1'b1});
    plan.push_back('{ROW_RANK, kls_pkg::rank_t'(1), '0, 1'b0, '0, 1'b0});  // lowered: keeps max
    plan.push_back('{ROW_SAMPLE, '0, 32'sd3, 1'b1, VMAX, 1'b1});
    plan.push_back('{ROW_RANK, kls_pkg::rank_t'(31), '0, 1'b0, '0, 1'b0});  // above capacity
    plan.push_back('{ROW_SAMPLE, '0, 32'sh5555_5555, 1'b1, 32'sh5555_5555, 1'b0});
    plan.push_back('{ROW_SAMPLE, '0, 32'shAAAA_AAAA, 1'b1, 32'shAAAA_AAAA, 1'b0});
    plan.push_back('{ROW_RANK, kls_pkg::rank_t'(17), '0, 1'b0, '0, 1'b0});
    plan.push_back('{ROW_SAMPLE, '0, 32'sd0, 1'b0, '0, 1'b0});
    plan.push_back('{ROW_RANK, kls_pkg::rank_t'(16), '0, 1'b0, '0, 1'b0});
    plan.push_back('{ROW_SAMPLE, '0, 32'sd100, 1'b0, '0, 1'b0});
    plan.push_back('{ROW_SAMPLE, '0, -32'sd100, 1'b0, '0, 1'b0});
    plan.push_back('{ROW_RANK, kls_pkg::rank_t'(2), '0, 1'b0, '0, 1'b0});
    plan.push_back('{ROW_SAMPLE, '0, 32'sd1, 1'b0, '0, 1'b0});
    plan.push_back('{ROW_SAMPLE, '0, VMIN, 1'b0, '0, 1'b0});

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_RANK) begin
        set_rank(plan[i].rank);
      end else begin
        hand_res.kth = plan[i].kth;
        hand_res.filled = plan[i].filled;
        send_sample(plan[i].val, plan[i].typed, hand_res);
      end
    end

    // Random phases: new rank each phase (state carries over, so lowering
    // truncates and raising refills), then a run of mixed-range samples.
    items = 0;
    while (items < RAND_ITEMS) begin
      case ($urandom_range(0, 7))
        0: new_rank = kls_pkg::rank_t'(0);
        1: new_rank = kls_pkg::rank_t'(MAX_RANK);
        2: new_rank = kls_pkg::rank_t'($urandom_range(MAX_RANK + 1, 31));
        3: new_rank = kls_pkg::rank_t'(1);
        default: new_rank = kls_pkg::rank_t'($urandom_range(2, MAX_RANK - 1));
      endcase
      set_rank(new_rank);
      phase_len = $urandom_range(20, 160);
      repeat (phase_len) begin
        // narrow range gives plenty of ties; full range and extremes for the rest
        case ($urandom_range(0, 9))
          0: v = ($urandom_range(0, 1) != 0) ? VMAX : VMIN;
          1, 2, 3, 4: v = kls_pkg::value_t'($urandom_range(0, 40)) - 32'sd20;
          default: v = kls_pkg::value_t'($urandom);
        endcase
        send_sample(v, 1'b0, '0);
        items++;
      end
    end

    if (in_valid) in_valid <= 1'b0;
    while (kth_expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (errors == 0 && kth_expected.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/kls_pkg.sv
rtl/kls_slot.sv
rtl/kth_largest_stream_tracker.sv
rtl/kls_checker.sv
test/tb.sv
